// ----- hdl/smasmu_pkg.sv -----
package smasmu_pkg;

    // Sizing of the matrix stores and the arithmetic.
    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;
    localparam int CELLS      = MAX_DIM * MAX_DIM;
    localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int PROD_W     = 2 * ELEM_WIDTH;

    // Fixed field widths of the stream and register interfaces.
    localparam int FLD_IDX_W = 3;
    localparam int IN_VAL_W  = 16;
    localparam int RES_W     = 35;
    localparam int REG_W     = 4;
    localparam int MODE_W    = 2;
    localparam int OP_W      = 2;

    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CELL_W-1:0]            t_cell;
    typedef logic [DIM_W-1:0]             t_dim;
    typedef logic signed [ELEM_WIDTH-1:0] t_elem;
    typedef logic signed [RES_W-1:0]      t_res;
    typedef logic [OP_W-1:0]              t_op;
    typedef logic [MODE_W-1:0]            t_mode;
    typedef logic [1:0]                   t_reg_idx;

    // Operation codes carried in tuser.
    localparam t_op OP_WR_A    = 2'd0;
    localparam t_op OP_WR_B    = 2'd1;
    localparam t_op OP_COMPUTE = 2'd2;

    // Arithmetic mode codes.
    localparam t_mode MODE_ADD = 2'd0;
    localparam t_mode MODE_SUB = 2'd1;
    localparam t_mode MODE_MUL = 2'd2;

    // Register indexes on the configuration port.
    localparam t_reg_idx REG_ROW_COUNT  = 2'd0;
    localparam t_reg_idx REG_COL_COUNT  = 2'd1;
    localparam t_reg_idx REG_ARITH_MODE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  wr_a;
        logic  wr_b;
        t_cell wr_addr;
        logic  rd;
        logic  first;
        logic  endk;
        logic  last;
        logic  mul;
        logic  sub;
        t_cell a_addr;
        t_cell b_addr;
        t_idx  row;
        t_idx  col;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic en;
        logic busy;
    } t_stat;

    // Row-major cell address of a matrix element.
    function automatic t_cell cell_addr(t_idx r, t_idx c);
        return CELL_W'(r) * CELL_W'(MAX_DIM) + CELL_W'(c);
    endfunction

endpackage

// ----- hdl/small_matrix_add_sub_multiply_unit.sv -----
// Signed integer matrix unit. Elements of A and B are written one transaction each
// (tuser selects A, B or compute; tdata carries row, column and a 16-bit value); a
// write is taken whenever no compute runs. A compute transaction streams the result in
// row-major order with tlast on the final element: A+B or A-B over row_count by
// col_count, or the square product A*B of size row_count. Results come out of a
// pipeline built around one memory read port per store and a single shared
// multiply-accumulate: add and subtract issue one element per cycle while the output
// is not stalled, multiply accumulates n products per element for size n. The first
// element passes through the read data registers, the product register and the
// accumulator into the output register. No input is taken while a compute runs;
// writes are taken again while the last result still waits in the output register.
// Back-pressure on the output stalls the whole pipeline.
// Registers: row_count at 0x0, col_count at 0x4, arith_mode at 0x8 (0 add, 1 A-B,
// 2 multiply, 3 emits nothing). Read only elements that have been written.
module small_matrix_add_sub_multiply_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // row_index[2:0], col_index[5:3], element_value[21:6]
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_row[2:0], out_col[5:3], result_value[40:6]
    output logic        m_axis_tlast   // last_result
);

    logic [smasmu_pkg::REG_W-1:0] r_row_count, r_col_count;
    smasmu_pkg::t_mode            r_arith_mode;
    smasmu_pkg::t_reg_idx         reg_idx;
    logic                         cfg_write;

    smasmu_pkg::t_cmd  cmd;
    smasmu_pkg::t_stat stat;

    logic [smasmu_pkg::FLD_IDX_W-1:0] out_row, out_col;
    smasmu_pkg::t_res                 out_value;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= smasmu_pkg::REG_W'(8);
            r_col_count  <= smasmu_pkg::REG_W'(8);
            r_arith_mode <= smasmu_pkg::MODE_ADD;
        end else if (cfg_write) begin
            case (reg_idx)
                smasmu_pkg::REG_ROW_COUNT:  r_row_count  <= pwdata[smasmu_pkg::REG_W-1:0];
                smasmu_pkg::REG_COL_COUNT:  r_col_count  <= pwdata[smasmu_pkg::REG_W-1:0];
                smasmu_pkg::REG_ARITH_MODE: r_arith_mode <= pwdata[smasmu_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            smasmu_pkg::REG_ROW_COUNT:  prdata = 32'(r_row_count);
            smasmu_pkg::REG_COL_COUNT:  prdata = 32'(r_col_count);
            smasmu_pkg::REG_ARITH_MODE: prdata = 32'(r_arith_mode);
            default:                    prdata = '0;
        endcase
    end

    smasmu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_row       (s_axis_tdata[2:0]),
        .i_col       (s_axis_tdata[5:3]),
        .i_row_count (r_row_count),
        .i_col_count (r_col_count),
        .i_mode      (r_arith_mode),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    smasmu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_data   (s_axis_tdata[21:6]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_out_value (out_value),
        .o_out_last  (m_axis_tlast),
        .o_stat      (stat)
    );

    // Pack the result fields, padded to whole bytes.
    assign m_axis_tdata = {7'b0, out_value, out_col, out_row};

endmodule

// ----- hdl/smasmu_ctrl.sv -----
module smasmu_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  smasmu_pkg::t_op                      i_op,
    input  logic [smasmu_pkg::FLD_IDX_W-1:0]     i_row,
    input  logic [smasmu_pkg::FLD_IDX_W-1:0]     i_col,
    input  logic [smasmu_pkg::REG_W-1:0]         i_row_count,
    input  logic [smasmu_pkg::REG_W-1:0]         i_col_count,
    input  smasmu_pkg::t_mode                    i_mode,
    input  smasmu_pkg::t_stat                    i_stat,
    output smasmu_pkg::t_cmd                     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_state           r_state, n_state;
    smasmu_pkg::t_idx r_i, r_j, r_k;
    smasmu_pkg::t_idx n_i, n_j, n_k;

    smasmu_pkg::t_dim rows, cols;
    smasmu_pkg::t_idx row_max, col_max, k_max;
    logic             is_mul, valid_mode, in_range;
    logic             endk, endj, endi;

    // A size of zero counts as one, a size above the store counts as the store size.
    function automatic smasmu_pkg::t_dim clamp_dim(logic [smasmu_pkg::REG_W-1:0] v);
        if (v == '0) begin
            return smasmu_pkg::t_dim'(1);
        end
        if (32'(v) > smasmu_pkg::MAX_DIM) begin
            return smasmu_pkg::DIM_W'(smasmu_pkg::MAX_DIM);
        end
        return smasmu_pkg::DIM_W'(v);
    endfunction

    // Loop bounds for the current mode.
    always_comb begin
        is_mul     = (i_mode == smasmu_pkg::MODE_MUL);
        valid_mode = (i_mode == smasmu_pkg::MODE_ADD) || (i_mode == smasmu_pkg::MODE_SUB) ||
                     (i_mode == smasmu_pkg::MODE_MUL);
        rows       = clamp_dim(i_row_count);
        cols       = is_mul ? rows : clamp_dim(i_col_count);
        row_max    = smasmu_pkg::IDX_W'(rows - 1'b1);
        col_max    = smasmu_pkg::IDX_W'(cols - 1'b1);
        k_max      = is_mul ? row_max : '0;
        endk       = (r_k == k_max);
        endj       = (r_j == col_max);
        endi       = (r_i == row_max);
        in_range   = (32'(i_row) < smasmu_pkg::MAX_DIM) && (32'(i_col) < smasmu_pkg::MAX_DIM);
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer: element writes in idle, one read pair per unstalled cycle over i, j, k, then drain.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;

        o_cmd         = '0;
        o_cmd.wr_addr = smasmu_pkg::cell_addr(smasmu_pkg::IDX_W'(i_row),
                                              smasmu_pkg::IDX_W'(i_col));
        o_cmd.mul     = is_mul;
        o_cmd.sub     = (i_mode == smasmu_pkg::MODE_SUB);
        o_cmd.a_addr  = smasmu_pkg::cell_addr(r_i, is_mul ? r_k : r_j);
        o_cmd.b_addr  = smasmu_pkg::cell_addr(is_mul ? r_k : r_i, r_j);
        o_cmd.row     = r_i;
        o_cmd.col     = r_j;
        o_cmd.first   = (r_k == '0);
        o_cmd.endk    = endk;
        o_cmd.last    = endk && endj && endi;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.wr_a = (i_op == smasmu_pkg::OP_WR_A) && in_range;
                    o_cmd.wr_b = (i_op == smasmu_pkg::OP_WR_B) && in_range;
                    if ((i_op == smasmu_pkg::OP_COMPUTE) && valid_mode) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.rd = 1'b1;
                if (i_stat.en) begin
                    if (endk) begin
                        n_k = '0;
                        if (endj) begin
                            n_j = '0;
                            if (endi) begin
                                n_state = S_DRAIN;
                            end else begin
                                n_i = r_i + 1'b1;
                            end
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

endmodule

// ----- hdl/smasmu_dpath.sv -----
module smasmu_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smasmu_pkg::t_cmd                     i_cmd,
    input  logic signed [smasmu_pkg::IN_VAL_W-1:0] i_wr_data,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [smasmu_pkg::FLD_IDX_W-1:0]     o_out_row,
    output logic [smasmu_pkg::FLD_IDX_W-1:0]     o_out_col,
    output smasmu_pkg::t_res                     o_out_value,
    output logic                                 o_out_last,
    output smasmu_pkg::t_stat                    o_stat
);

    typedef struct packed {
        logic             first;
        logic             endk;
        logic             last;
        logic             mul;
        logic             sub;
        smasmu_pkg::t_idx row;
        smasmu_pkg::t_idx col;
    } t_meta;

    smasmu_pkg::t_elem r_mem_a [smasmu_pkg::CELLS];
    smasmu_pkg::t_elem r_mem_b [smasmu_pkg::CELLS];

    smasmu_pkg::t_elem r_a_q, r_b_q;
    logic              r_s1_vld, r_s2_vld, r_o_vld;
    t_meta             r_s1, r_s2, n_meta;

    logic signed [smasmu_pkg::PROD_W-1:0] r_prod, n_prod;
    smasmu_pkg::t_res                     r_acc, n_sum;
    smasmu_pkg::t_res                     r_o_value;
    smasmu_pkg::t_idx                     r_o_row, r_o_col;
    logic                                 r_o_last;
    logic                                 en;

    // The whole pipeline moves only when the output register can take a result.
    assign en          = !r_o_vld || i_out_ready;
    assign o_stat.en   = en;
    assign o_stat.busy = r_s1_vld || r_s2_vld;

    assign n_meta.first = i_cmd.first;
    assign n_meta.endk  = i_cmd.endk;
    assign n_meta.last  = i_cmd.last;
    assign n_meta.mul   = i_cmd.mul;
    assign n_meta.sub   = i_cmd.sub;
    assign n_meta.row   = i_cmd.row;
    assign n_meta.col   = i_cmd.col;

    // Matrix stores: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[i_cmd.wr_addr] <= smasmu_pkg::ELEM_WIDTH'(i_wr_data);
        end
        if (i_cmd.wr_b) begin
            r_mem_b[i_cmd.wr_addr] <= smasmu_pkg::ELEM_WIDTH'(i_wr_data);
        end
        if (en && i_cmd.rd) begin
            r_a_q <= r_mem_a[i_cmd.a_addr];
            r_b_q <= r_mem_b[i_cmd.b_addr];
        end
    end

    // Shared multiplier, or the adder or subtractor for elementwise modes.
    always_comb begin
        if (r_s1.mul) begin
            n_prod = smasmu_pkg::PROD_W'(r_a_q) * smasmu_pkg::PROD_W'(r_b_q);
        end else if (r_s1.sub) begin
            n_prod = smasmu_pkg::PROD_W'(r_a_q) - smasmu_pkg::PROD_W'(r_b_q);
        end else begin
            n_prod = smasmu_pkg::PROD_W'(r_a_q) + smasmu_pkg::PROD_W'(r_b_q);
        end
    end

    // Accumulator restarts on the first term of each result element.
    always_comb begin
        if (r_s2.first) begin
            n_sum = smasmu_pkg::RES_W'(r_prod);
        end else begin
            n_sum = r_acc + smasmu_pkg::RES_W'(r_prod);
        end
    end

    // Stage valids and output register handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (en) begin
                r_s1_vld <= i_cmd.rd;
                r_s2_vld <= r_s1_vld;
            end
            if (en && r_s2_vld && r_s2.endk) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1   <= n_meta;
            r_s2   <= r_s1;
            r_prod <= n_prod;
            if (r_s2_vld) begin
                r_acc <= n_sum;
                if (r_s2.endk) begin
                    r_o_value <= n_sum;
                    r_o_row   <= r_s2.row;
                    r_o_col   <= r_s2.col;
                    r_o_last  <= r_s2.last;
                end
            end
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_row   = smasmu_pkg::FLD_IDX_W'(r_o_row);
    assign o_out_col   = smasmu_pkg::FLD_IDX_W'(r_o_col);
    assign o_out_value = r_o_value;
    assign o_out_last  = r_o_last;

    // A stalled output freezes every stage of the pipeline.
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !i_out_ready) |=> ($stable(r_s1_vld) && $stable(r_s2_vld)))
        else $error("pipeline advanced while the output was stalled");

    // Stores are written only while no read is in flight.
    a_write_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_a || i_cmd.wr_b) |-> (!r_s1_vld && !r_s2_vld && !i_cmd.rd))
        else $error("store written during a compute");

    // A new result comes only from the accumulator stage.
    a_out_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_vld) |-> $past(r_s2_vld && r_s2.endk))
        else $error("output loaded without a finished element");

endmodule
